FILE: rtl/core/prc_pkg.sv
// ----------------------------------------------------------------------------
// prc_pkg
// Shared types and constants of the priority range classifier.
// ----------------------------------------------------------------------------
package prc_pkg;

	localparam int MaxEntries = 64;
	localparam int IdxW = $clog2(MaxEntries);
	localparam int CntW = $clog2(MaxEntries + 1);

	localparam logic [1:0] FUNC_REG = 2'd0;
	localparam logic [1:0] FUNC_LOOKUP = 2'd1;
	localparam logic [1:0] FUNC_CLASSIFY = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;

	// one stored rule: id and four lo/hi bound pairs
	typedef struct packed {
		logic [7:0] id;
		logic [7:0][31:0] bnd; // lo,hi for temp, precip, humid, height
	} rule_t;

	// controller to datapath
	typedef struct packed {
		logic cap;        // capture input item
		logic scan_clr;   // restart scan index
		logic scan_inc;   // advance scan index
		logic wr;         // write rule table
		logic wr_at_scan; // write at scan index, else at count
		logic cnt_inc;
		logic dflt_sel;   // write default rule instead of input
		logic [1:0] dflt_idx;
		logic set_found;  // result from scanned entry
		logic set_res;    // result from controller fields
		logic [1:0] res_status;
		logic res_id_new; // result id = stored id of new entry
	} prc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] func;
		logic id_zero;
		logic empty;
		logic full;
		logic scan_end;  // scan index reached count
		logic id_hit;    // entry at scan index has input id (valid in the cycle after the read)
		logic cls_hit;
	} prc_sts_t;

	function automatic rule_t default_rule(input logic [1:0] k);
		rule_t r;
		r.id = {6'd0, k} + 8'd1;
		unique case (k)
			2'd0: r.bnd = {32'd0, 32'd0, 32'(1 << 16), 32'(1 << 15),
				32'(4 << 16), 32'(1 << 16), 32'(305 << 16), 32'(270 << 16)};
			2'd1: r.bnd = {32'd0, 32'd0, 32'(1 << 15), 32'd0,
				32'(1 << 16), 32'd0, 32'(350 << 16), 32'(285 << 16)};
			2'd2: r.bnd = {32'd0, 32'(300 << 16), 32'(1 << 16), 32'd0,
				32'(2 << 16), 32'd0, 32'(275 << 16), 32'd0};
			default: r.bnd = {32'(100 << 16), 32'd0, 32'd0, 32'(1 << 15),
				32'd0, 32'(2 << 16), 32'(320 << 16), 32'(260 << 16)};
		endcase
		return r;
	endfunction

	function automatic logic in_range(input logic [31:0] v, input logic [31:0] lo,
		input logic [31:0] hi);
		if (lo == 32'd0 && hi == 32'd0) return 1'b1;
		if ($signed(v) < $signed(lo)) return 1'b0;
		if (hi != 32'd0 && $signed(hi) < $signed(v)) return 1'b0;
		return 1'b1;
	endfunction

endpackage

FILE: rtl/core/prc_datapath.sv
// ----------------------------------------------------------------------------
// prc_datapath
// Rule memory, scan index, entry count, compare logic and result register.
// ----------------------------------------------------------------------------
module prc_datapath import prc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  prc_cmd_t cmd,
	output prc_sts_t sts,
	input  logic [1:0] func,
	input  logic [7:0] type_id,
	input  logic [7:0][31:0] fld,
	output logic [1:0] res_status,
	output logic [7:0] res_id,
	output logic [7:0][31:0] res_bnd
);

	logic [1:0] func_q;
	logic [7:0] id_q;
	logic [7:0][31:0] fld_q;
	logic [CntW-1:0] count_q;
	logic [CntW-1:0] scan_q;
	rule_t mem [MaxEntries];
	rule_t rd_q;
	rule_t wdata;
	logic [IdxW-1:0] waddr;
	logic [7:0] new_id;

	// hold the item
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			func_q <= func;
			id_q <= type_id;
			fld_q <= fld;
		end
	end

	// scan index and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			scan_q <= '0;
		end else begin
			if (cmd.scan_clr) scan_q <= '0;
			else if (cmd.scan_inc) scan_q <= scan_q + 1'b1;
			if (cmd.cnt_inc) count_q <= count_q + 1'b1;
		end
	end

	assign new_id = (id_q == 8'd0) ? 8'(count_q + 1'b1) : id_q;
	assign waddr = cmd.wr_at_scan ? scan_q[IdxW-1:0] : count_q[IdxW-1:0];

	always_comb begin
		if (cmd.dflt_sel) wdata = default_rule(cmd.dflt_idx);
		else begin
			wdata.id = new_id;
			wdata.bnd = fld_q;
		end
	end

	// rule memory, registered read at scan index
	always_ff @(posedge clk) begin
		if (cmd.wr) mem[waddr] <= wdata;
		rd_q <= mem[scan_q[IdxW-1:0]];
	end

	assign sts.func = func_q;
	assign sts.id_zero = (id_q == 8'd0);
	assign sts.empty = (count_q == '0);
	assign sts.full = (count_q >= CntW'(MaxEntries));
	assign sts.scan_end = (scan_q >= count_q);
	assign sts.id_hit = (rd_q.id == id_q);
	assign sts.cls_hit = in_range(fld_q[0], rd_q.bnd[0], rd_q.bnd[1])
		&& in_range(fld_q[2], rd_q.bnd[2], rd_q.bnd[3])
		&& in_range(fld_q[4], rd_q.bnd[4], rd_q.bnd[5])
		&& in_range(fld_q[6], rd_q.bnd[6], rd_q.bnd[7]);

	// result register
	always_ff @(posedge clk) begin
		if (cmd.set_found) begin
			res_status <= ST_OK;
			res_id <= rd_q.id;
			res_bnd <= (func_q == FUNC_LOOKUP) ? rd_q.bnd : '0;
		end else if (cmd.set_res) begin
			res_status <= cmd.res_status;
			res_id <= cmd.res_id_new ? (cmd.wr_at_scan ? id_q : new_id) : 8'd0;
			res_bnd <= '0;
		end
	end

endmodule

FILE: rtl/core/prc_ctrl.sv
// ----------------------------------------------------------------------------
// prc_ctrl
// Sequencer: captures an item, scans the rule table, loads defaults, writes.
// ----------------------------------------------------------------------------
module prc_ctrl import prc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  prc_sts_t sts,
	output prc_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE, S_DISPATCH, S_DFLT, S_READ, S_CHECK, S_DONE
	} state_t;

	state_t state_q;
	logic [1:0] dflt_q;

	// accept only out of reset, when idle and no result waits
	assign in_ready = arst_n && (state_q == S_IDLE) && !out_valid;

	always_comb begin
		cmd = '0;
		cmd.dflt_idx = dflt_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.cap = in_valid && in_ready;
				cmd.scan_clr = 1'b1;
			end
			S_DISPATCH: begin
				cmd.scan_clr = 1'b1;
				if (sts.func == FUNC_REG && sts.full) begin
					cmd.set_res = 1'b1;
					cmd.res_status = ST_FULL;
				end else if (sts.func == FUNC_LOOKUP && sts.id_zero) begin
					cmd.set_res = 1'b1;
					cmd.res_status = ST_NOTFOUND;
				end else if (sts.func == 2'd3) begin
					cmd.set_res = 1'b1;
					cmd.res_status = ST_OK;
				end
			end
			S_DFLT: begin
				cmd.wr = 1'b1;
				cmd.dflt_sel = 1'b1;
				cmd.cnt_inc = 1'b1;
				cmd.scan_clr = 1'b1;
			end
			S_READ: ;
			S_CHECK: begin
				// scanned entry in rd register; scan index still points at it
				if (sts.scan_end) begin
					cmd.set_res = 1'b1;
					if (sts.func == FUNC_REG) begin
						cmd.wr = 1'b1;
						cmd.cnt_inc = 1'b1;
						cmd.res_id_new = 1'b1;
						cmd.res_status = ST_OK;
					end else if (sts.func == FUNC_LOOKUP) cmd.res_status = ST_NOTFOUND;
					else cmd.res_status = ST_OK;
				end else if (sts.func == FUNC_REG && sts.id_hit && !sts.id_zero) begin
					cmd.wr = 1'b1;
					cmd.wr_at_scan = 1'b1;
					cmd.set_res = 1'b1;
					cmd.res_id_new = 1'b1;
					cmd.res_status = ST_OK;
				end else if (sts.func == FUNC_LOOKUP && sts.id_hit) begin
					cmd.set_found = 1'b1;
				end else if (sts.func == FUNC_CLASSIFY && sts.cls_hit) begin
					cmd.set_found = 1'b1;
				end else begin
					cmd.scan_inc = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			dflt_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (cmd.cap) state_q <= S_DISPATCH;
				S_DISPATCH: begin
					dflt_q <= '0;
					if (cmd.set_res) begin
						out_valid <= 1'b1;
						state_q <= S_IDLE;
					end else if (sts.func == FUNC_CLASSIFY && sts.empty) state_q <= S_DFLT;
					else state_q <= S_READ;
				end
				S_DFLT: begin
					dflt_q <= dflt_q + 2'd1;
					if (dflt_q == 2'd3) state_q <= S_READ;
				end
				S_READ: state_q <= S_CHECK;
				S_CHECK: begin
					if (cmd.set_res || cmd.set_found) begin
						out_valid <= 1'b1;
						state_q <= S_DONE;
					end else state_q <= S_READ;
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/core/priority_range_classifier.sv
// Each scanned rule is read into a register (S_READ) and then checked (S_CHECK);
// classify on an empty table first loads the four default rules.
// Throughput: one item at a time; the next is taken once the result is transferred.
// The scan rate is set by the single registered read port of the rule memory.
// Reset clears the entry count and control state; rule memory is not cleared.
// ----------------------------------------------------------------------------
// priority_range_classifier
// First-match multi-field range classifier over an ordered rule table.
// ----------------------------------------------------------------------------
module priority_range_classifier import prc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [1:0] func,
	input  logic [7:0] type_id,
	input  logic signed [31:0] temp_a,
	input  logic signed [31:0] temp_b,
	input  logic signed [31:0] precip_a,
	input  logic signed [31:0] precip_b,
	input  logic signed [31:0] humid_a,
	input  logic signed [31:0] humid_b,
	input  logic signed [31:0] height_a,
	input  logic signed [31:0] height_b,
	output logic out_valid,
	input  logic out_ready,
	output logic [1:0] status,
	output logic [7:0] result_id,
	output logic signed [31:0] out_temp_lo,
	output logic signed [31:0] out_temp_hi,
	output logic signed [31:0] out_precip_lo,
	output logic signed [31:0] out_precip_hi,
	output logic signed [31:0] out_humid_lo,
	output logic signed [31:0] out_humid_hi,
	output logic signed [31:0] out_height_lo,
	output logic signed [31:0] out_height_hi
);

	prc_cmd_t cmd;
	prc_sts_t sts;
	logic [7:0][31:0] fld;
	logic [7:0][31:0] res_bnd;

	assign fld = {height_b, height_a, humid_b, humid_a, precip_b, precip_a, temp_b, temp_a};

	prc_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
	);

	prc_datapath u_dp (
		.clk, .arst_n, .cmd, .sts, .func, .type_id, .fld,
		.res_status(status), .res_id(result_id), .res_bnd
	);

	assign out_temp_lo = res_bnd[0];
	assign out_temp_hi = res_bnd[1];
	assign out_precip_lo = res_bnd[2];
	assign out_precip_hi = res_bnd[3];
	assign out_humid_lo = res_bnd[4];
	assign out_humid_hi = res_bnd[5];
	assign out_height_lo = res_bnd[6];
	assign out_height_hi = res_bnd[7];

endmodule

FILE: rtl/core/prc_checker.sv
// ----------------------------------------------------------------------------
// prc_checker
// Port-level checks of the classifier, bound to the top level.
// ----------------------------------------------------------------------------
module prc_checker import prc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [1:0] status,
	input logic [7:0] result_id
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(result_id))
		else $error("result changed while stalled");

	// no transfer in while a result waits
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken while result pending");

	// accepted item gives no result in the next cycle
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid)
		else $error("result too early");

	// full status never carries an id
	a_full_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> result_id == 8'd0)
		else $error("full status with id");

endmodule

bind priority_range_classifier prc_checker u_prc_checker (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .status, .result_id
);
